// ----- src/modbus_tcp_read_register_responder_macros.svh -----
// Assertion macros used by the responder back end.
`ifndef MODBUS_TCP_READ_REGISTER_RESPONDER_MACROS_SVH
`define MODBUS_TCP_READ_REGISTER_RESPONDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBTCP_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBTCP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mbtcp_pkg.sv -----
// Shared types and constants for the Modbus TCP read-register responder.
package mbtcp_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CONN  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PDU    = 2'd1,
    PH_IDLE   = 2'd2
  } phase_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_EMIT = 1'b1
  } back_state_e;

  localparam logic [7:0]  FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0]  FC_READ_INPUT    = 8'h04;
  localparam logic [7:0]  EXC_FLAG         = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
  localparam logic [15:0] MAX_QTY          = 16'd125;
  localparam logic [15:0] MIN_LEN          = 16'd2;
  localparam logic [15:0] MAX_LEN          = 16'd253;
  localparam logic [15:0] MIN_READ_LEN     = 16'd6;
  localparam logic [8:0]  HDR_LAST         = 9'd6;

  // One reply to build, classified by the front end.
  typedef struct packed {
    logic [15:0] tid;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic        ok;
    logic [7:0]  exc;
    logic [15:0] start;
    logic [6:0]  qty;
  } job_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [15:0] value;
  } tbl_wr_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

// ----- src/mbtcp_front.sv -----
// Front end: MBAP/PDU parser, request classification, table write requests.
module mbtcp_front import mbtcp_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  input  back_stat_t  stat_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output job_t        job_o,
  output tbl_wr_t     wr_o
);

  phase_e      phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [15:0] tid_q, tid_d;
  logic [15:0] flen_q, flen_d;
  logic [7:0]  unit_q, unit_d;
  logic [7:0]  func_q, func_d;
  logic [15:0] start_q, start_d;
  logic [15:0] qty_q, qty_d;
  logic [8:0]  tsize_q;

  op_e         op;
  logic        fire;
  logic        byte_fire;
  logic [8:0]  pdu_cnt_inc;
  logic        pdu_done;
  logic        hdr_done;
  logic        len_bad;
  logic [16:0] valid_cnt;
  logic        is_read;
  logic        range_bad;

  assign op          = op_e'(op_i);
  assign in_ready_o  = !stat_i.clearing && !fifo_full_i && !(op == OP_WRITE && stat_i.busy);
  assign fire        = in_valid_i && in_ready_o;
  assign byte_fire   = fire && (op == OP_BYTE);
  assign pdu_cnt_inc = cnt_q + 9'd1;
  assign pdu_done    = ({7'd0, pdu_cnt_inc} + 16'd1) >= flen_q;
  assign hdr_done    = cnt_q >= HDR_LAST;
  assign len_bad     = (flen_q < MIN_LEN) || (flen_q > MAX_LEN);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire && op == OP_CONN) begin
      phase_d = PH_HEADER;
    end else if (byte_fire) begin
      case (phase_q)
        PH_HEADER: begin
          if (hdr_done) begin
            phase_d = len_bad ? PH_IDLE : PH_PDU;
          end
        end
        PH_PDU: begin
          if (pdu_done) begin
            phase_d = PH_IDLE;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // field capture and byte counter
  always_comb begin
    cnt_d   = cnt_q;
    tid_d   = tid_q;
    flen_d  = flen_q;
    unit_d  = unit_q;
    func_d  = func_q;
    start_d = start_q;
    qty_d   = qty_q;
    if (fire && op == OP_CONN) begin
      cnt_d = 9'd0;
    end else if (byte_fire) begin
      case (phase_q)
        PH_HEADER: begin
          case (cnt_q)
            9'd0:    tid_d = {rx_byte_i, 8'h00};
            9'd1:    tid_d = {tid_q[15:8], rx_byte_i};
            9'd4:    flen_d = {rx_byte_i, 8'h00};
            9'd5:    flen_d = {flen_q[15:8], rx_byte_i};
            9'd6:    unit_d = rx_byte_i;
            default: ;
          endcase
          cnt_d = hdr_done ? 9'd0 : pdu_cnt_inc;
        end
        PH_PDU: begin
          case (cnt_q)
            9'd0:    func_d = rx_byte_i;
            9'd1:    start_d = {rx_byte_i, 8'h00};
            9'd2:    start_d = {start_q[15:8], rx_byte_i};
            9'd3:    qty_d = {rx_byte_i, 8'h00};
            9'd4:    qty_d = {qty_q[15:8], rx_byte_i};
            default: ;
          endcase
          cnt_d = pdu_done ? 9'd0 : pdu_cnt_inc;
        end
        default: ;
      endcase
    end
  end

  // classification of the finished request
  always_comb begin
    valid_cnt = ({8'd0, tsize_q} > 17'(TABLE_DEPTH)) ? 17'(TABLE_DEPTH) : {8'd0, tsize_q};
    is_read   = ((func_d == FC_READ_HOLDING) || (func_d == FC_READ_INPUT)) &&
                (flen_q >= MIN_READ_LEN);
    range_bad = (qty_d == 16'd0) || (qty_d > MAX_QTY) ||
                (({1'b0, start_d} + {1'b0, qty_d}) > valid_cnt);
    push_o     = byte_fire && (phase_q == PH_PDU) && pdu_done;
    job_o.tid   = tid_q;
    job_o.unit  = unit_q;
    job_o.func  = func_d;
    job_o.ok    = is_read && !range_bad;
    job_o.exc   = is_read ? EXC_ILLEGAL_ADDR : EXC_ILLEGAL_FUNC;
    job_o.start = start_d;
    job_o.qty   = qty_d[6:0];
    wr_o.en    = fire && (op == OP_WRITE) && (32'(entry_index_i) < 32'(TABLE_DEPTH));
    wr_o.index = entry_index_i;
    wr_o.value = entry_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= 9'd0;
      tid_q   <= 16'd0;
      flen_q  <= 16'd0;
      unit_q  <= 8'd0;
      func_q  <= 8'd0;
      start_q <= 16'd0;
      qty_q   <= 16'd0;
      tsize_q <= 9'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      tid_q   <= tid_d;
      flen_q  <= flen_d;
      unit_q  <= unit_d;
      func_q  <= func_d;
      start_q <= start_d;
      qty_q   <= qty_d;
      if (cfg_we_i) begin
        tsize_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- src/mbtcp_fifo.sv -----
// Two-entry reply job queue between front and back end.
module mbtcp_fifo import mbtcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  job_t       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign head_o  = entry_q[rd_ptr_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/mbtcp_back.sv -----
// Back end: register table memory, reply byte sequencer, 8-byte chunk packer.
`include "modbus_tcp_read_register_responder_macros.svh"
module mbtcp_back import mbtcp_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tbl_wr_t     wr_i,
  input  logic        fifo_empty_i,
  input  job_t        fifo_head_i,
  output logic        pop_o,
  output back_stat_t  stat_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [63:0] resp_bytes_o,
  output logic [3:0]  resp_count_o,
  output logic        resp_last_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [15:0]   mem [TABLE_DEPTH];
  logic [15:0]   rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  logic          clearing_q;
  logic [AW-1:0] clr_q;

  back_state_e   state_q, state_d;
  job_t          job_q, job_d;
  logic [8:0]    p_q, p_d;
  logic [63:0]   asm_q, asm_d;
  logic [3:0]    cnt_q, cnt_d;

  logic          out_valid_q, out_valid_d;
  logic [63:0]   out_bytes_q, out_bytes_d;
  logic [3:0]    out_count_q, out_count_d;
  logic          out_last_q, out_last_d;

  logic [8:0]    last_idx;
  logic          is_last;
  logic [7:0]    rlen;
  logic [7:0]    byte_sel;
  logic [3:0]    cnt_inc;
  logic          need_flush;
  logic          slot_free;
  logic          advance;
  logic [63:0]   asm_n;
  logic [8:0]    p_off;

  // table memory: clearing sweep after reset, then front-end writes
  assign mem_we    = clearing_q || wr_i.en;
  assign mem_waddr = clearing_q ? clr_q : AW'(wr_i.index);
  assign mem_wdata = clearing_q ? 16'd0 : wr_i.value;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(TABLE_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign stat_o.clearing = clearing_q;
  assign stat_o.busy     = (state_q != B_IDLE) || !fifo_empty_i;

  // reply geometry
  assign last_idx   = job_q.ok ? (9'd8 + {1'b0, job_q.qty, 1'b0}) : 9'd8;
  assign is_last    = p_q == last_idx;
  assign rlen       = job_q.ok ? ({job_q.qty, 1'b0} + 8'd3) : 8'd3;
  assign cnt_inc    = cnt_q + 4'd1;
  assign need_flush = (cnt_inc == 4'd8) || is_last;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign advance    = (state_q == B_EMIT) && (!need_flush || slot_free);

  always_comb begin
    case (p_q)
      9'd0:    byte_sel = job_q.tid[15:8];
      9'd1:    byte_sel = job_q.tid[7:0];
      9'd2:    byte_sel = 8'h00;
      9'd3:    byte_sel = 8'h00;
      9'd4:    byte_sel = 8'h00;
      9'd5:    byte_sel = rlen;
      9'd6:    byte_sel = job_q.unit;
      9'd7:    byte_sel = job_q.ok ? job_q.func : (job_q.func | EXC_FLAG);
      9'd8:    byte_sel = job_q.ok ? {job_q.qty, 1'b0} : job_q.exc;
      // data area: odd positions carry the high byte of a word
      default: byte_sel = p_q[0] ? rd_q[15:8] : rd_q[7:0];
    endcase
  end

  assign asm_n = asm_q | ({byte_sel, 56'd0} >> {cnt_q[2:0], 3'b000});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i && !clearing_q) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (advance && is_last) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o       = (state_q == B_IDLE) && !fifo_empty_i && !clearing_q;
    job_d       = job_q;
    p_d         = p_q;
    asm_d       = asm_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_bytes_d = out_bytes_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    if (pop_o) begin
      job_d = fifo_head_i;
      p_d   = 9'd0;
      asm_d = 64'd0;
      cnt_d = 4'd0;
    end else if (advance) begin
      p_d = p_q + 9'd1;
      if (need_flush) begin
        asm_d       = 64'd0;
        cnt_d       = 4'd0;
        out_valid_d = 1'b1;
        out_bytes_d = asm_n;
        out_count_d = cnt_inc;
        out_last_d  = is_last;
      end else begin
        asm_d = asm_n;
        cnt_d = cnt_inc;
      end
    end
    // read one word ahead so rd_q matches p_q
    p_off   = p_d - 9'd9;
    rd_addr = AW'(job_d.start) + AW'(p_off[8:1]);
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    asm_q       <= asm_d;
    out_bytes_q <= out_bytes_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      p_q         <= 9'd0;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign resp_bytes_o = out_bytes_q;
  assign resp_count_o = out_count_q;
  assign resp_last_o  = out_last_q;

  `MBTCP_ASSERT_IMPLY(a_count_range, clk_i, rst_ni, out_valid_q, (out_count_q != 4'd0) && (out_count_q <= 4'd8), "chunk byte count out of range")
  `MBTCP_ASSERT_IMPLY(a_quiet_clear, clk_i, rst_ni, clearing_q, !out_valid_q && (state_q == B_IDLE), "reply activity during table clear")
  `MBTCP_ASSERT_IMPLY(a_partial_chunk, clk_i, rst_ni, state_q == B_EMIT, cnt_q < 4'd8, "chunk packer overran")
  `MBTCP_ASSERT_IMPLY(a_write_idle, clk_i, rst_ni, wr_i.en, (state_q == B_IDLE) && fifo_empty_i, "table write while a reply is pending")
  `MBTCP_ASSERT_NEXT(a_pop_starts, clk_i, rst_ni, pop_o, (state_q == B_EMIT) && (p_q == 9'd0), "dequeued job did not start")

endmodule

// ----- src/modbus_tcp_read_register_responder.sv -----
// Top level of the Modbus TCP read-register responder.
//
//  channel   direction  handshake              beat carries
//  -------   ---------  ---------------------  -----------------------------------------
//  in        sink       in_valid_i/in_ready_o  op, rx_byte, entry_index, entry_value
//  out       source     out_valid_o/out_ready_i resp_bytes, resp_count, resp_last
//  cfg       sink       cfg_we_i (no wait)     table_size in cfg_wdata_i
//
//  Flow: one request beat per cycle while in_ready_o is high; the back end takes a job,
//  then emits one reply byte per cycle unless stalled, a reply of 9 + 2*quantity bytes (9 for
//  an exception), at most 259 bytes in 33 chunks.
//  Reset: a clearing sweep zeroes the table, in_ready_o low, cfg taken.
//  Stalls: in_ready_o drops while the two-job queue is full, and for table writes while a
//  reply is queued or in progress; out_ready_i low stalls the builder at full and last chunks.
module modbus_tcp_read_register_responder import mbtcp_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  // request side
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  // reply side
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] resp_bytes_o,
  output logic [3:0]  resp_count_o,
  output logic        resp_last_o
);

  back_stat_t stat;
  tbl_wr_t    wr;
  job_t       job_in;
  job_t       job_head;
  logic       push;
  logic       pop;
  logic       fifo_full;
  logic       fifo_empty;

  // Parser: MBAP header, PDU fields, classification into ok / exception 1 / exception 2.
  mbtcp_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .stat_i       (stat),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .job_o        (job_in),
    .wr_o         (wr)
  );

  // Reply jobs waiting for the builder.
  mbtcp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .head_o (job_head),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  // Register table and reply builder; the table is read when the job is carried out,
  // which matches request time because writes are held off while a job is pending.
  mbtcp_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .fifo_empty_i(fifo_empty),
    .fifo_head_i (job_head),
    .pop_o       (pop),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .resp_bytes_o(resp_bytes_o),
    .resp_count_o(resp_count_o),
    .resp_last_o (resp_last_o)
  );

endmodule
